### rtl/aarm_pkg.sv
// ----------------------------------------------------------------------------
// aarm_pkg
// Shared constants, types and the arctangent table function for the axis-angle rotation matrix.
// ----------------------------------------------------------------------------
package aarm_pkg;

    localparam int ELEMENT_FRACTION_BITS_DEF = 14;
    localparam int CORDIC_STAGES = 30;
    localparam int SQRT_STAGES = 32;
    localparam int DIV_STAGES = 31;

    localparam logic signed [33:0] CORDIC_GAIN_Q30 = 34'sd652032874;
    localparam logic signed [34:0] PI_Q30 = 35'sd3373259426;
    localparam logic signed [34:0] HALF_PI_Q30 = 35'sd1686629713;
    localparam logic signed [35:0] TWO_PI_Q30 = 36'sd6746518852;
    localparam logic signed [31:0] ONE_Q30 = 32'sd1073741824;

    // carried along the chain beside each angle
    typedef struct packed {
        logic signed [33:0] x;
        logic signed [33:0] y;
        logic signed [35:0] z;
        logic               neg;
    } t_rot;

    // one item travelling the axis chain
    typedef struct packed {
        logic [15:0] mag_x;
        logic [15:0] mag_y;
        logic [15:0] mag_z;
        logic        sgn_x;
        logic        sgn_y;
        logic        sgn_z;
        logic        zero;
    } t_axis;

    function automatic logic signed [30:0] atan_q30(input int i);
        unique case (i)
            0: atan_q30 = 31'sd843314856;
            1: atan_q30 = 31'sd497837829;
            2: atan_q30 = 31'sd263043836;
            3: atan_q30 = 31'sd133525158;
            4: atan_q30 = 31'sd67021686;
            5: atan_q30 = 31'sd33543515;
            6: atan_q30 = 31'sd16775850;
            7: atan_q30 = 31'sd8388437;
            8: atan_q30 = 31'sd4194282;
            9: atan_q30 = 31'sd2097149;
            10: atan_q30 = 31'sd1048575;
            11: atan_q30 = 31'sd524287;
            12: atan_q30 = 31'sd262143;
            13: atan_q30 = 31'sd131071;
            14: atan_q30 = 31'sd65535;
            15: atan_q30 = 31'sd32767;
            16: atan_q30 = 31'sd16383;
            17: atan_q30 = 31'sd8191;
            18: atan_q30 = 31'sd4095;
            19: atan_q30 = 31'sd2047;
            20: atan_q30 = 31'sd1023;
            21: atan_q30 = 31'sd511;
            22: atan_q30 = 31'sd255;
            23: atan_q30 = 31'sd127;
            24: atan_q30 = 31'sd63;
            25: atan_q30 = 31'sd31;
            26: atan_q30 = 31'sd15;
            27: atan_q30 = 31'sd8;
            28: atan_q30 = 31'sd4;
            29: atan_q30 = 31'sd2;
            default: atan_q30 = 31'sd0;
        endcase
    endfunction

endpackage

### rtl/aarm_cordic_cell.sv
// ----------------------------------------------------------------------------
// aarm_cordic_cell
// One rotation stage of the sine/cosine chain, registered on advance.
// ----------------------------------------------------------------------------
module aarm_cordic_cell #(
    parameter int STAGE = 0
) (
    input  logic           i_clk,
    input  logic           i_en,
    input  aarm_pkg::t_rot i_rot,
    output aarm_pkg::t_rot o_rot
);
    import aarm_pkg::*;

    t_rot               r_rot;
    t_rot               n_rot;
    logic signed [33:0] dx;
    logic signed [33:0] dy;

    // arithmetic shift gives floor division
    always_comb begin
        dx = i_rot.y >>> STAGE;
        dy = i_rot.x >>> STAGE;
        n_rot.neg = i_rot.neg;
        if (!i_rot.z[35]) begin
            n_rot.x = i_rot.x - dx;
            n_rot.y = i_rot.y + dy;
            n_rot.z = i_rot.z - 36'(atan_q30(STAGE));
        end else begin
            n_rot.x = i_rot.x + dx;
            n_rot.y = i_rot.y - dy;
            n_rot.z = i_rot.z + 36'(atan_q30(STAGE));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) r_rot <= n_rot;
    end

    assign o_rot = r_rot;
endmodule

### rtl/aarm_sqrt_cell.sv
// ----------------------------------------------------------------------------
// aarm_sqrt_cell
// One digit of the restoring square root of the axis length squared.
// ----------------------------------------------------------------------------
module aarm_sqrt_cell #(
    parameter int STAGE = 0
) (
    input  logic              i_clk,
    input  logic              i_en,
    input  logic [31:0]       i_sq,
    input  logic [33:0]       i_rem,
    input  logic [31:0]       i_root,
    input  aarm_pkg::t_axis   i_ax,
    output logic [31:0]       o_sq,
    output logic [33:0]       o_rem,
    output logic [31:0]       o_root,
    output aarm_pkg::t_axis   o_ax
);
    import aarm_pkg::*;

    // radicand is sq << 32 bits (64 bits total), 32 root bits
    localparam int POS = 2 * (SQRT_STAGES - 1 - STAGE);

    logic [63:0] rad;
    logic [35:0] n_rem_t;
    logic [35:0] trial;
    logic [33:0] r_rem;
    logic [31:0] r_root;
    logic [31:0] r_sq;
    t_axis       r_ax;
    logic        take;

    always_comb begin
        rad = {i_sq, 32'd0};
        n_rem_t = {i_rem, rad[POS+1], rad[POS]};
        trial = {2'b00, i_root, 2'b01};
        take = (n_rem_t >= trial);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem <= take ? 34'(n_rem_t - trial) : n_rem_t[33:0];
            r_root <= {i_root[30:0], take};
            r_sq <= i_sq;
            r_ax <= i_ax;
        end
    end

    assign o_rem = r_rem;
    assign o_root = r_root;
    assign o_sq = r_sq;
    assign o_ax = r_ax;
endmodule

### rtl/aarm_div_cell.sv
// ----------------------------------------------------------------------------
// aarm_div_cell
// One quotient bit for all three axis components by the common root.
// ----------------------------------------------------------------------------
module aarm_div_cell #(
    parameter int STAGE = 0
) (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [30:0] i_num,
    input  logic [31:0] i_rem [3],
    input  logic [30:0] i_q [3],
    input  logic [31:0] i_den,
    output logic [30:0] o_num,
    output logic [31:0] o_rem [3],
    output logic [30:0] o_q [3],
    output logic [31:0] o_den
);
    import aarm_pkg::*;

    localparam int POS = DIV_STAGES - 1 - STAGE;

    logic [30:0] r_num;
    logic [31:0] r_rem [3];
    logic [30:0] r_q [3];
    logic [31:0] r_den;
    logic [32:0] t [3];
    logic        take [3];

    // shift in one numerator bit per lane and trial-subtract
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            t[k] = {i_rem[k], i_num[POS]};
            take[k] = (t[k] >= {1'b0, i_den});
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < 3; k++) begin
                r_rem[k] <= take[k] ? 32'(t[k] - {1'b0, i_den}) : t[k][31:0];
                r_q[k] <= {i_q[k][29:0], take[k]};
            end
            r_num <= i_num;
            r_den <= i_den;
        end
    end

    assign o_num = r_num;
    assign o_rem = r_rem;
    assign o_q = r_q;
    assign o_den = r_den;
endmodule

### rtl/axis_angle_rotation_matrix.sv
// ----------------------------------------------------------------------------
// axis_angle_rotation_matrix
// Rodrigues rotation matrix from angle and axis, one request per cycle unless the output stalls.
// ----------------------------------------------------------------------------
// channel | dir | fields (tdata lsb up)
// s_axis  | in  | angle, axis_x, axis_y, axis_z (64 bits)
// m_axis  | out | c0r0..c2r2 (144 bits); tuser: zero_axis
//
// One request per cycle sustained while the output is not stalled; latency is set
// by the root and divide cell chains (the rotation chain is shorter and delayed
// to match). The whole pipeline advances only when the output register is free
// or being drained, so a stall freezes every cell.
// Synchronous active-low reset clears the valid bits only.
module axis_angle_rotation_matrix
    import aarm_pkg::*;
#(
    parameter int ELEMENT_FRACTION_BITS = ELEMENT_FRACTION_BITS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // angle, axis_x, axis_y, axis_z
    input  logic [63:0]  s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // c0r0, c0r1, c0r2, c1r0, c1r1, c1r2, c2r0, c2r1, c2r2
    output logic [143:0] m_axis_tdata,
    // zero_axis
    output logic         m_axis_tuser
);
    localparam int LAT = 2 + SQRT_STAGES + DIV_STAGES + 3;
    localparam int SH = 60 - ELEMENT_FRACTION_BITS;

    logic en;
    logic [LAT-1:0] r_vld;

    assign en = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = en;

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[LAT-2:0], s_axis_tvalid};
        end
    end
    assign m_axis_tvalid = r_vld[LAT-1];

    // stage 0: angle reduction, axis magnitudes and squared components
    logic signed [35:0] za;
    logic signed [35:0] zr;
    logic               zneg;
    logic signed [15:0] ax [3];
    t_rot  r_rot0;
    t_axis r_ax0;
    logic [31:0] r_sq0;
    logic [31:0] r_sqp [3];

    always_comb begin
        za = 36'(signed'(s_axis_tdata[15:0])) <<< 18;
        if (za > 36'(PI_Q30)) za = za - TWO_PI_Q30;
        else if (za < -36'(PI_Q30)) za = za + TWO_PI_Q30;
        zneg = 1'b0;
        zr = za;
        if (za > 36'(HALF_PI_Q30)) begin
            zr = za - 36'(PI_Q30);
            zneg = 1'b1;
        end else if (za < -36'(HALF_PI_Q30)) begin
            zr = za + 36'(PI_Q30);
            zneg = 1'b1;
        end
        for (int k = 0; k < 3; k++) ax[k] = signed'(s_axis_tdata[16*k+16 +: 16]);
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_rot0.x <= CORDIC_GAIN_Q30;
            r_rot0.y <= '0;
            r_rot0.z <= zr;
            r_rot0.neg <= zneg;
            r_ax0.mag_x <= ax[0][15] ? 16'(-ax[0]) : ax[0];
            r_ax0.mag_y <= ax[1][15] ? 16'(-ax[1]) : ax[1];
            r_ax0.mag_z <= ax[2][15] ? 16'(-ax[2]) : ax[2];
            r_ax0.sgn_x <= ax[0][15];
            r_ax0.sgn_y <= ax[1][15];
            r_ax0.sgn_z <= ax[2][15];
            r_ax0.zero <= (ax[0] == 0) && (ax[1] == 0) && (ax[2] == 0);
            for (int k = 0; k < 3; k++) r_sqp[k] <= 32'(ax[k] * ax[k]);
        end
    end

    // stage 1: sum of squares, below 2^32 for any axis
    t_axis r_ax1;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sq0 <= r_sqp[0] + r_sqp[1] + r_sqp[2];
            r_ax1 <= r_ax0;
        end
    end

    // rotation chain
    t_rot rot [CORDIC_STAGES+1];
    assign rot[0] = r_rot0;
    for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cordic
        aarm_cordic_cell #(.STAGE(g)) u_cell (
            .i_clk(i_clk), .i_en(en), .i_rot(rot[g]), .o_rot(rot[g+1])
        );
    end

    // delay sine/cosine to line up with the divide output
    localparam int RDLY = 1 + SQRT_STAGES + DIV_STAGES - CORDIC_STAGES;
    logic signed [33:0] r_cd [RDLY];
    logic signed [33:0] r_sd [RDLY];
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_cd[0] <= rot[CORDIC_STAGES].neg ? -rot[CORDIC_STAGES].x : rot[CORDIC_STAGES].x;
            r_sd[0] <= rot[CORDIC_STAGES].neg ? -rot[CORDIC_STAGES].y : rot[CORDIC_STAGES].y;
            for (int k = 1; k < RDLY; k++) begin
                r_cd[k] <= r_cd[k-1];
                r_sd[k] <= r_sd[k-1];
            end
        end
    end

    // root chain: m = floor(sqrt(S * 2^32))
    logic [31:0] sq [SQRT_STAGES+1];
    logic [33:0] rem [SQRT_STAGES+1];
    logic [31:0] root [SQRT_STAGES+1];
    t_axis       axc [SQRT_STAGES+1];
    assign sq[0] = r_sq0;
    assign rem[0] = '0;
    assign root[0] = '0;
    assign axc[0] = r_ax1;
    for (genvar g = 0; g < SQRT_STAGES; g++) begin : g_sqrt
        aarm_sqrt_cell #(.STAGE(g)) u_cell (
            .i_clk(i_clk), .i_en(en), .i_sq(sq[g]), .i_rem(rem[g]), .i_root(root[g]),
            .i_ax(axc[g]), .o_sq(sq[g+1]), .o_rem(rem[g+1]), .o_root(root[g+1]),
            .o_ax(axc[g+1])
        );
    end

    // numerator mag*2^46 + m/2 holds mag << 15 from bit 31 up and m/2 below;
    // the upper part is below m and seeds the remainder, the low 31 bits
    // give one quotient bit per cell
    logic [30:0] num [DIV_STAGES+1];
    logic [31:0] drem [DIV_STAGES+1][3];
    logic [30:0] q [DIV_STAGES+1][3];
    logic [31:0] den [DIV_STAGES+1];
    logic [15:0] mg [3];
    assign mg[0] = axc[SQRT_STAGES].mag_x;
    assign mg[1] = axc[SQRT_STAGES].mag_y;
    assign mg[2] = axc[SQRT_STAGES].mag_z;
    assign num[0] = root[SQRT_STAGES][31:1];
    for (genvar k = 0; k < 3; k++) begin : g_num
        assign drem[0][k] = {1'b0, mg[k], 15'd0};
        assign q[0][k] = '0;
    end
    assign den[0] = axc[SQRT_STAGES].zero ? 32'd1 : root[SQRT_STAGES];

    for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
        aarm_div_cell #(.STAGE(g)) u_cell (
            .i_clk(i_clk), .i_en(en), .i_num(num[g]), .i_rem(drem[g]), .i_q(q[g]),
            .i_den(den[g]), .o_num(num[g+1]), .o_rem(drem[g+1]), .o_q(q[g+1]),
            .o_den(den[g+1])
        );
    end

    // axis flags travel beside the divide chain
    t_axis r_axd [DIV_STAGES];
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_axd[0] <= axc[SQRT_STAGES];
            for (int k = 1; k < DIV_STAGES; k++) r_axd[k] <= r_axd[k-1];
        end
    end

    // signed unit axis
    logic signed [31:0] u [3];
    logic [2:0] sg;
    assign sg = {r_axd[DIV_STAGES-1].sgn_z, r_axd[DIV_STAGES-1].sgn_y,
                 r_axd[DIV_STAGES-1].sgn_x};
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            if (r_axd[DIV_STAGES-1].zero) u[k] = '0;
            else u[k] = sg[k] ? -signed'({1'b0, q[DIV_STAGES][k]})
                             : signed'({1'b0, q[DIV_STAGES][k]});
        end
    end

    // product stage a: pair products, sine terms, cosine terms
    logic signed [63:0] r_pp [6];
    logic signed [65:0] r_us [3];
    logic signed [65:0] r_cc;
    logic signed [34:0] r_cv;
    logic               r_z2;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_pp[0] <= u[0] * u[0];
            r_pp[1] <= u[0] * u[1];
            r_pp[2] <= u[0] * u[2];
            r_pp[3] <= u[1] * u[1];
            r_pp[4] <= u[1] * u[2];
            r_pp[5] <= u[2] * u[2];
            for (int k = 0; k < 3; k++) r_us[k] <= 66'(u[k]) * 66'(r_sd[RDLY-1]);
            r_cc <= 66'(r_cd[RDLY-1]) <<< 30;
            r_cv <= 35'(ONE_Q30) - 35'(r_cd[RDLY-1]);
            r_z2 <= r_axd[DIV_STAGES-1].zero;
        end
    end

    // product stage b: scale rounded pair products by 1-cos
    logic signed [33:0] pr [6];
    logic signed [69:0] r_pc [6];
    logic signed [65:0] r_us2 [3];
    logic signed [65:0] r_cc2;
    logic               r_z3;
    always_comb begin
        for (int k = 0; k < 6; k++) pr[k] = 34'((r_pp[k] + (64'sd1 <<< 29)) >>> 30);
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < 6; k++) r_pc[k] <= 70'(pr[k]) * 70'(r_cv);
            r_us2 <= r_us;
            r_cc2 <= r_cc;
            r_z3 <= r_z2;
        end
    end

    // terms, rounding and saturation
    logic signed [69:0] t [9];
    logic [15:0] el [9];
    always_comb begin
        t[0] = r_pc[0] + 70'(r_cc2);
        t[1] = r_pc[1] + 70'(r_us2[2]);
        t[2] = r_pc[2] - 70'(r_us2[1]);
        t[3] = r_pc[1] - 70'(r_us2[2]);
        t[4] = r_pc[3] + 70'(r_cc2);
        t[5] = r_pc[4] + 70'(r_us2[0]);
        t[6] = r_pc[2] + 70'(r_us2[1]);
        t[7] = r_pc[4] - 70'(r_us2[0]);
        t[8] = r_pc[5] + 70'(r_cc2);
        for (int k = 0; k < 9; k++) begin
            logic signed [69:0] e;
            e = (t[k] + (70'sd1 <<< (SH - 1))) >>> SH;
            if (e > 70'sd32767) el[k] = 16'h7fff;
            else if (e < -70'sd32768) el[k] = 16'h8000;
            else el[k] = e[15:0];
        end
    end

    logic [143:0] r_out;
    logic         r_zo;
    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < 9; k++) r_out[16*k +: 16] <= el[k];
            r_zo <= r_z3;
        end
    end
    assign m_axis_tdata = r_out;
    assign m_axis_tuser = r_zo;
endmodule

### rtl/aarm_checker.sv
// ----------------------------------------------------------------------------
// aarm_checker
// Port-level checks on the rotation matrix stream.
// ----------------------------------------------------------------------------
module aarm_checker (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         s_axis_tvalid,
    input logic         s_axis_tready,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [143:0] m_axis_tdata,
    input logic         m_axis_tuser
);
    // stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result changed under stall");

    // input ready whenever output is free
    a_rdy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with empty output");

    // zero axis leaves off-diagonal terms c0r1, c0r2 and c2r1 zero
    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[31:16] == 16'd0
            && m_axis_tdata[47:32] == 16'd0 && m_axis_tdata[127:112] == 16'd0)
        else $error("zero axis with off-diagonal term");

    // ready follows the output side stall
    a_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
        else $error("input taken during output stall");
endmodule

bind axis_angle_rotation_matrix aarm_checker u_aarm_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready), .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata),
    .m_axis_tuser(m_axis_tuser)
);
